[sv/rlex_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlex_pkg
// Shared types and constants for the run-length expander: field widths,
// parser phase codes and the command beat from the parser to the engine.
// ----------------------------------------------------------------------------
package rlex_pkg;

    // default store size in bytes
    localparam int DEF_STORE_DEPTH = 4096;

    // result field widths
    localparam int ADDR_W        = 12;
    localparam int CNT_W         = 4;
    localparam int BYTES_PER_ROW = 8;
    localparam int DATA_W        = 8 * BYTES_PER_ROW;
    localparam int LANE_W        = $clog2(BYTES_PER_ROW);

    // parser phase codes
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_REPEAT  = 2'd1;
    localparam logic [1:0] PH_LITERAL = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    // command from the parser to the expansion engine
    typedef struct packed {
        logic       go;        // start a result-producing job
        logic       done_row;  // job is the end-of-stream row
        logic       clr_pos;   // rewind write position to zero
        logic [7:0] value;     // byte to write
        logic [7:0] count;     // number of copies, 1..129
    } rlex_cmd_t;

endpackage

[sv/rlex_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlex_in_if
// Input channel: one code byte per beat with a stream start flag.
// ----------------------------------------------------------------------------
interface rlex_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] code_byte;

    modport source (output valid, output start_req, output code_byte, input ready);
    modport sink   (input valid, input start_req, input code_byte, output ready);
endinterface

[sv/rlex_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlex_out_if
// Result channel: up to eight updated store bytes per beat plus status flags.
// ----------------------------------------------------------------------------
interface rlex_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] address;
    logic [3:0]  byte_count;
    logic [63:0] data;
    logic        run_last;
    logic        stream_done;
    logic        dropped;

    modport source (output valid, output address, output byte_count, output data,
                    output run_last, output stream_done, output dropped, input ready);
    modport sink   (input valid, input address, input byte_count, input data,
                    input run_last, input stream_done, input dropped, output ready);
endinterface

[sv/rle_expand_into_store.sv]
`timescale 1ns / 1ps
// A nonzero header beat is absorbed with no result.
// With a ready sink, a data beat writing n bytes moves one byte per cycle
// through the store read-merge-write port, with a read state before and an
// output state after each row of eight.
// in_ch.ready is low until the engine is back in its idle state.
// Reset (rst_n low, asynchronous) clears parser, position, mode and fill count.
// ----------------------------------------------------------------------------
// rle_expand_into_store
// Run-length decoder that expands a coded byte stream into a byte store,
// overwriting or OR-merging, and reports updated bytes in rows of eight.
// ----------------------------------------------------------------------------
module rle_expand_into_store
    import rlex_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    rlex_in_if.sink     in_ch,
    rlex_out_if.source  out_ch
);

    logic [1:0] phase_reg,  phase_next;
    logic [6:0] lit_reg,    lit_next;
    logic [7:0] rep_reg,    rep_next;
    logic       merge_reg;
    logic       accept;
    logic       eng_idle;
    logic [1:0] phase_eff;
    logic [6:0] lit_eff;
    logic [7:0] rep_eff;
    logic [6:0] lit_dec;
    rlex_cmd_t  cmd;

    assign in_ch.ready = eng_idle;
    assign accept      = in_ch.valid && in_ch.ready;

    // a start beat rewinds the parser before the byte is read
    assign phase_eff = in_ch.start_req ? PH_HEADER : phase_reg;
    assign lit_eff   = in_ch.start_req ? 7'd0 : lit_reg;
    assign rep_eff   = in_ch.start_req ? 8'd0 : rep_reg;
    assign lit_dec   = lit_eff - 7'd1;

    // header parser
    always_comb
    begin
        phase_next    = phase_reg;
        lit_next      = lit_reg;
        rep_next      = rep_reg;
        cmd.go        = 1'b0;
        cmd.done_row  = 1'b0;
        cmd.clr_pos   = accept && in_ch.start_req;
        cmd.value     = in_ch.code_byte;
        cmd.count     = 8'd1;

        if (accept)
        begin
            phase_next = phase_eff;
            lit_next   = lit_eff;
            rep_next   = rep_eff;
            unique case (phase_eff)
                PH_HEADER:
                begin
                    if (in_ch.code_byte == 8'd0)
                    begin
                        phase_next   = PH_DONE;
                        cmd.go       = 1'b1;
                        cmd.done_row = 1'b1;
                    end
                    else if (in_ch.code_byte[7])
                    begin
                        // run length 1 - h, i.e. 257 - code
                        rep_next   = 8'(9'd257 - {1'b0, in_ch.code_byte});
                        phase_next = PH_REPEAT;
                    end
                    else
                    begin
                        lit_next   = in_ch.code_byte[6:0];
                        phase_next = PH_LITERAL;
                    end
                end
                PH_REPEAT:
                begin
                    phase_next = PH_HEADER;
                    rep_next   = 8'd0;
                    cmd.go     = 1'b1;
                    cmd.count  = rep_eff;
                end
                PH_LITERAL:
                begin
                    lit_next = lit_dec;
                    if (lit_dec == 7'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                    cmd.go = 1'b1;
                end
                PH_DONE:
                begin
                    // stream ended: byte ignored
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            lit_reg   <= '0;
            rep_reg   <= '0;
            merge_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            rep_reg   <= rep_next;
            if (cfg_we)
            begin
                merge_reg <= cfg_wdata;
            end
        end
    end

    rlex_engine #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .merge_mode (merge_reg),
        .idle       (eng_idle),
        .out_ch     (out_ch)
    );

endmodule

[sv/rlex_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlex_store
// Byte store with one write and one registered read port. A fill count marks
// the written prefix; entries at or above it read as zero, as after reset.
// ----------------------------------------------------------------------------
module rlex_store
    import rlex_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
    output logic [7:0]                     rd_data,
    input  logic                           wr_en,
    input  logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
    input  logic [7:0]                     wr_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = AW + 1;

    logic [7:0]    mem [STORE_DEPTH];
    logic [7:0]    mem_q;
    logic          hit_reg;
    logic          hit_next;
    logic [PW-1:0] fill_reg;
    logic [PW-1:0] fill_next;

    // memory array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q <= mem[rd_addr];
    end

    // written prefix grows as the write position passes its end
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && (PW'(wr_addr) >= fill_reg))
        begin
            fill_next = PW'(wr_addr) + PW'(1);
        end
        hit_next = PW'(rd_addr) < fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            hit_reg  <= hit_next;
        end
    end

    // never-written entries read as zero
    assign rd_data = hit_reg ? mem_q : 8'd0;

endmodule

[sv/rlex_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlex_engine
// Expansion sequencer: walks the store one byte per cycle (pausing while a
// row waits) through a shared read-merge-write unit, packs updated bytes into
// rows of eight, each held in the output register until the sink takes it.
// ----------------------------------------------------------------------------
module rlex_engine
    import rlex_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  rlex_cmd_t       cmd,
    input  logic            merge_mode,
    output logic            idle,
    rlex_out_if.source      out_ch
);

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int PW   = AW + 1;
    localparam int CMPW = (PW > 8) ? PW : 8;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]        state_reg,    state_next;
    logic [PW-1:0]     pos_reg,      pos_next;
    logic [PW-1:0]     row_addr_reg, row_addr_next;
    logic [7:0]        todo_reg,     todo_next;
    logic [LANE_W-1:0] lane_reg,     lane_next;
    logic [7:0]        value_reg,    value_next;
    logic [CNT_W-1:0]  cnt_reg,      cnt_next;
    logic [DATA_W-1:0] data_reg,     data_next;
    logic              last_reg,     last_next;
    logic              done_reg,     done_next;
    logic              drop_reg,     drop_next;

    logic [PW-1:0]     pos_eff;
    logic [PW-1:0]     avail;
    logic [7:0]        todo_init;
    logic              drop_init;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic [7:0]        merged;

    rlex_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (pos_reg[AW-1:0]),
        .wr_data (merged)
    );

    // room left in the store and the clipped job length
    assign pos_eff   = cmd.clr_pos ? '0 : pos_reg;
    assign avail     = PW'(STORE_DEPTH) - pos_eff;
    assign drop_init = CMPW'(cmd.count) > CMPW'(avail);
    assign todo_init = drop_init ? 8'(avail) : cmd.count;

    // shared byte unit: overwrite or OR into the stored byte
    assign merged = merge_mode ? (rd_data | value_reg) : value_reg;

    // read ahead one byte while merging the current one
    assign rd_addr = (state_reg == S_MERGE) ? AW'(pos_reg + PW'(1)) : pos_reg[AW-1:0];

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        row_addr_next = row_addr_reg;
        todo_next     = todo_reg;
        lane_next     = lane_reg;
        value_next    = value_reg;
        cnt_next      = cnt_reg;
        data_next     = data_reg;
        last_next     = last_reg;
        done_next     = done_reg;
        drop_next     = drop_reg;
        wr_en         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                pos_next = pos_eff;
                if (cmd.go)
                begin
                    row_addr_next = pos_eff;
                    data_next     = '0;
                    lane_next     = '0;
                    cnt_next      = '0;
                    value_next    = cmd.value;
                    todo_next     = todo_init;
                    if (cmd.done_row)
                    begin
                        last_next  = 1'b1;
                        done_next  = 1'b1;
                        drop_next  = 1'b0;
                        state_next = S_OUT;
                    end
                    else if (todo_init == 8'd0)
                    begin
                        last_next  = 1'b1;
                        done_next  = 1'b0;
                        drop_next  = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        done_next  = 1'b0;
                        drop_next  = drop_init;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                wr_en     = 1'b1;
                data_next[{lane_reg, 3'b000} +: 8] = merged;
                pos_next  = pos_reg + PW'(1);
                todo_next = todo_reg - 8'd1;
                lane_next = lane_reg + LANE_W'(1);
                if ((lane_reg == LANE_W'(BYTES_PER_ROW - 1)) || (todo_reg == 8'd1))
                begin
                    cnt_next   = CNT_W'(lane_reg) + CNT_W'(1);
                    last_next  = (todo_reg == 8'd1);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    lane_next     = '0;
                    data_next     = '0;
                    row_addr_next = pos_reg;
                    state_next    = last_reg ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            row_addr_reg <= '0;
            todo_reg     <= '0;
            lane_reg     <= '0;
            value_reg    <= '0;
            cnt_reg      <= '0;
            data_reg     <= '0;
            last_reg     <= 1'b0;
            done_reg     <= 1'b0;
            drop_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            row_addr_reg <= row_addr_next;
            todo_reg     <= todo_next;
            lane_reg     <= lane_next;
            value_reg    <= value_next;
            cnt_reg      <= cnt_next;
            data_reg     <= data_next;
            last_reg     <= last_next;
            done_reg     <= done_next;
            drop_reg     <= drop_next;
        end
    end

    // result beat straight from the output registers
    assign idle               = (state_reg == S_IDLE);
    assign out_ch.valid       = (state_reg == S_OUT);
    assign out_ch.address     = ADDR_W'(row_addr_reg);
    assign out_ch.byte_count  = cnt_reg;
    assign out_ch.data        = data_reg;
    assign out_ch.run_last    = last_reg;
    assign out_ch.stream_done = done_reg;
    assign out_ch.dropped     = drop_reg;

    // checks
    a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_MERGE) |-> (todo_reg != 8'd0))
        else $error("engine busy with no bytes left");

    a_row_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (cnt_reg <= CNT_W'(BYTES_PER_ROW)))
        else $error("row holds more than eight bytes");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(STORE_DEPTH))
        else $error("write position beyond store end");

    a_done_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && done_reg) |-> (cnt_reg == '0 && last_reg && !drop_reg))
        else $error("end-of-stream row malformed");

    a_final_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE && todo_reg == 8'd1) |=> (state_reg == S_OUT && last_reg))
        else $error("last byte did not close the job");

endmodule
